FILE: rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int VALUE_W = 32;
    localparam int K_W     = 12;
    localparam int INDEX_W = 8;
    localparam int LEN_W   = 9;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_FIND       = 3'd5,
        OP_REVERSE    = 3'd6,
        OP_KTH_END    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  result_value;
        logic [INDEX_W-1:0]         found_index;
        logic [LEN_W-1:0]           list_length;
    } t_result;

endpackage

FILE: rtl/bdq_in_if.sv
interface bdq_in_if;
    import bdq_pkg::*;

    logic                      valid;
    logic                      ready;
    t_op                       op;
    logic signed [VALUE_W-1:0] data_value;
    logic [K_W-1:0]            position_from_end;

    modport source (output valid, output op, output data_value,
                    output position_from_end, input ready);
    modport sink   (input valid, input op, input data_value,
                    input position_from_end, output ready);
endinterface

FILE: rtl/bdq_out_if.sv
interface bdq_out_if;
    import bdq_pkg::*;

    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic signed [VALUE_W-1:0] result_value;
    logic [INDEX_W-1:0]        found_index;
    logic [LEN_W-1:0]          list_length;

    modport source (output valid, output status, output result_value,
                    output found_index, output list_length, input ready);
    modport sink   (input valid, input status, input result_value,
                    input found_index, input list_length, output ready);
endinterface

FILE: rtl/bdq_ram.sv
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/bounded_deque_with_search.sv
// Bounded double-ended queue of signed 32-bit values with a linear search.
//
// The input channel carries one operation per word: push back, push front,
// pop front, pop back, peek front, find, reverse, or read the k-th value
// counted from the back. The output channel returns exactly one word per
// input word with a status, the value read, the index of a find hit and
// the length after the operation.
//
// The entries live in one synchronous RAM with a registered read, and a word
// is taken only while the control is idle. Push, reverse and any operation
// that fails at once pass through the hold state to the output register; a
// pop, peek or k-th that reads the RAM passes through the read state and then
// the hold state. Find compares one entry per cycle, at most DEPTH entries,
// before the hold state. A new word can be taken in the cycle the previous
// result turns valid, and not before.
//
// When the receiver stalls, a result waits in the output register while the
// next word is processed; a second finished result holds the control, which
// takes no new word until the register frees up. Reset empties the queue and
// clears the direction flag; the RAM contents are left as they are.
module bounded_deque_with_search #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bdq_in_if.sink            i_in,
    bdq_out_if.source         o_out
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_W   = (CW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_FIND = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    // Control and queue state.
    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic            r_rev, n_rev;
    logic [AW-1:0]   r_idx, n_idx;
    logic [VALUE_W-1:0] r_key, n_key;
    t_result         r_res, n_res;

    // Output register.
    logic            r_ovalid, n_ovalid;
    t_result         r_out, n_out;

    // RAM port signals.
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [VALUE_W-1:0] w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [VALUE_W-1:0] w_rdata;

    logic               w_accept;
    logic               w_out_free;

    bdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Physical slot of a logical position counted from the front. In normal
    // order the front is the low end of the occupied region; reversed, the
    // front is the high end.
    function automatic logic [AW-1:0] f_slot(input logic [CW-1:0] pos);
        logic [CW:0] off;
        logic [CW:0] sum;
        if (r_rev) begin
            off = {1'b0, r_count} - (CW+1)'(1) - {1'b0, pos};
        end else begin
            off = {1'b0, pos};
        end
        sum = (CW+1)'(r_head) + off;
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    // Resize a count or index to a result field, wrapping as the field does.
    function automatic logic [LEN_W-1:0] f_len(input logic [CW-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[LEN_W-1:0];
    endfunction

    function automatic logic [INDEX_W-1:0] f_index(input logic [AW-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[INDEX_W-1:0];
    endfunction

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;

    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_out.status;
    assign o_out.result_value = r_out.result_value;
    assign o_out.found_index  = r_out.found_index;
    assign o_out.list_length  = r_out.list_length;

    always_comb begin
        logic [CW:0]     hi_sum;
        logic [K_W-1:0]  k_eff;
        logic [CW-1:0]   idx_inc;
        logic            side_high;

        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_rev    = r_rev;
        n_idx    = r_idx;
        n_key    = r_key;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_out    = r_out;

        w_we     = 1'b0;
        w_waddr  = r_head;
        w_wdata  = i_in.data_value;
        w_raddr  = f_slot('0);

        hi_sum = (CW+1)'(r_head) + {1'b0, r_count};
        if (hi_sum >= DEPTH_W) begin
            hi_sum = hi_sum - DEPTH_W;
        end
        k_eff     = (i_in.position_from_end == '0) ? K_W'(1) : i_in.position_from_end;
        idx_inc   = CW'(r_idx) + CW'(1);
        side_high = 1'b0;

        // A taken result frees the output register.
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res.status       = ST_OK;
                    n_res.result_value = '0;
                    n_res.found_index  = '0;
                    n_state            = S_HOLD;
                    case (i_in.op)
                        OP_PUSH_BACK, OP_PUSH_FRONT: begin
                            side_high = (i_in.op == OP_PUSH_BACK) != r_rev;
                            if (r_count == CW'(DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                                if (side_high) begin
                                    w_waddr = hi_sum[AW-1:0];
                                end else begin
                                    n_head  = (r_head == '0) ? LAST_SLOT
                                                             : r_head - AW'(1);
                                    w_waddr = n_head;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                side_high = (i_in.op == OP_POP_FRONT) == r_rev;
                                w_raddr   = (i_in.op == OP_POP_FRONT)
                                            ? f_slot('0)
                                            : f_slot(r_count - CW'(1));
                                n_count   = r_count - CW'(1);
                                if (!side_high) begin
                                    n_head = (r_head == LAST_SLOT) ? '0
                                                                   : r_head + AW'(1);
                                end
                                n_state = S_READ;
                            end
                        end
                        OP_PEEK_FRONT: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                w_raddr = f_slot('0);
                                n_state = S_READ;
                            end
                        end
                        OP_FIND: begin
                            n_key = i_in.data_value;
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_res.status = ST_NOTFOUND;
                            end else begin
                                w_raddr = f_slot('0);
                                n_state = S_FIND;
                            end
                        end
                        OP_REVERSE: begin
                            n_rev = !r_rev;
                        end
                        OP_KTH_END: begin
                            if (32'(k_eff) > 32'(r_count)) begin
                                n_res.status = ST_NOTFOUND;
                            end else begin
                                w_raddr = f_slot(CW'(32'(r_count) - 32'(k_eff)));
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_res.status = ST_OK;
                        end
                    endcase
                    n_res.list_length = f_len(n_count);
                end
            end

            // The RAM word read at acceptance is on the read port now.
            S_READ: begin
                n_res.result_value = w_rdata;
                n_state            = S_HOLD;
            end

            // One entry compared and the next one fetched in every cycle.
            S_FIND: begin
                w_raddr = f_slot(idx_inc);
                if (w_rdata == r_key) begin
                    n_res.status      = ST_OK;
                    n_res.found_index = f_index(r_idx);
                    n_state           = S_HOLD;
                end else if (idx_inc == r_count) begin
                    n_res.status = ST_NOTFOUND;
                    n_state      = S_HOLD;
                end else begin
                    n_idx = idx_inc[AW-1:0];
                end
            end

            S_HOLD: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_rev    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_rev    <= n_rev;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_key <= n_key;
        r_res <= n_res;
        r_out <= n_out;
    end
endmodule
